// ===== hdl/sps_pkg.sv =====
// Package for the sphere point sampler: payload types, constants and the CORDIC angle table.
// No dependencies.
package sps_pkg;

  localparam int TWISTER_WORDS = 624;
  localparam int FRAC_BITS = 30;
  localparam int MT_SHIFT_M = 397;
  localparam int CORDIC_STEPS = 30;
  localparam logic [31:0] INV_GAIN_Q30 = 32'd652032874;
  localparam logic [31:0] MT_MULT = 32'd1812433253;
  localparam logic [31:0] MT_MATRIX = 32'h9908b0df;

  localparam logic [1:0] CFG_SEED_ANGLE = 2'd0;
  localparam logic [1:0] CFG_SEED_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_SEED_RADIUS = 2'd2;

  typedef struct packed {
    logic action;
    logic last_request;
  } sps_in_t;

  typedef struct packed {
    logic signed [31:0] x_coord;
    logic signed [31:0] y_coord;
    logic signed [31:0] z_coord;
    logic last_point;
  } sps_out_t;

  // Control between the top level and a generator.
  typedef struct packed {
    logic seed;
    logic draw;
  } sps_gen_ctl_t;

  typedef struct packed {
    logic busy;
    logic word_valid;
  } sps_gen_sts_t;

  function automatic logic [31:0] cordic_angle(input logic [4:0] i);
    logic [31:0] a;
    begin
      case (i)
        5'd0: a = 32'd536870912;  5'd1: a = 32'd316933406;
        5'd2: a = 32'd167458907;  5'd3: a = 32'd85004756;
        5'd4: a = 32'd42667331;   5'd5: a = 32'd21354465;
        5'd6: a = 32'd10679838;   5'd7: a = 32'd5340245;
        5'd8: a = 32'd2670163;    5'd9: a = 32'd1335087;
        5'd10: a = 32'd667544;    5'd11: a = 32'd333772;
        5'd12: a = 32'd166886;    5'd13: a = 32'd83443;
        5'd14: a = 32'd41722;     5'd15: a = 32'd20861;
        5'd16: a = 32'd10430;     5'd17: a = 32'd5215;
        5'd18: a = 32'd2608;      5'd19: a = 32'd1304;
        5'd20: a = 32'd652;       5'd21: a = 32'd326;
        5'd22: a = 32'd163;       5'd23: a = 32'd81;
        5'd24: a = 32'd41;        5'd25: a = 32'd20;
        5'd26: a = 32'd10;        5'd27: a = 32'd5;
        5'd28: a = 32'd3;         5'd29: a = 32'd1;
        default: a = 32'd0;
      endcase
      return a;
    end
  endfunction

endpackage

// ===== hdl/sps_twister.sv =====
// One MT19937 generator: 624-word state memory, seeding sweep, lazy twist and tempering.
// Depends on sps_pkg.
module sps_twister #(
  parameter int WORDS = sps_pkg::TWISTER_WORDS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  sps_pkg::sps_gen_ctl_t ctl,
  input  logic [31:0]           seed_val,
  output sps_pkg::sps_gen_sts_t sts,
  output logic [31:0]           word
);
  import sps_pkg::*;

  localparam int AW = $clog2(WORDS);
  localparam int PW = $clog2(WORDS + 1);
  localparam logic [AW-1:0] LAST = AW'(WORDS - 1);
  localparam logic [PW-1:0] FULL = PW'(WORDS);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SEED = 4'd1;
  localparam logic [3:0] S_TW0 = 4'd2;  // read i
  localparam logic [3:0] S_TW1 = 4'd3;  // read i+1
  localparam logic [3:0] S_TW2 = 4'd4;  // read i+m
  localparam logic [3:0] S_TW3 = 4'd5;  // write i
  localparam logic [3:0] S_RD0 = 4'd6;
  localparam logic [3:0] S_RD1 = 4'd7;
  localparam logic [3:0] S_TEMP = 4'd8;
  localparam logic [3:0] S_REQ = 4'd9;

  logic [31:0] mem [WORDS];
  logic [31:0] rdata_r;
  logic [AW-1:0] raddr;
  logic we;
  logic [AW-1:0] waddr;
  logic [31:0] wdata;

  logic [3:0] state_r, state_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic [PW-1:0] pos_r, pos_nxt;
  logic [31:0] prev_r, prev_nxt, hi_r, hi_nxt, lo_r, lo_nxt, word_r, word_nxt;
  logic valid_r, valid_nxt, pend_r, pend_nxt;
  logic [31:0] y, t, mix, sd;
  logic [AW:0] ip1, ipm;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_r <= mem[raddr];
  end

  always_comb begin
    ip1 = {1'b0, idx_r} + 1'b1;
    if (ip1 >= (AW+1)'(WORDS)) ip1 = ip1 - (AW+1)'(WORDS);
    ipm = {1'b0, idx_r} + (AW+1)'(MT_SHIFT_M);
    if (ipm >= (AW+1)'(WORDS)) ipm = ipm - (AW+1)'(WORDS);
    mix = {hi_r[31], lo_r[30:0]};
    sd = MT_MULT * (prev_r ^ (prev_r >> 30)) + 32'(idx_r);
    t = rdata_r;
    t = t ^ (t >> 11);
    t = t ^ ((t << 7) & 32'h9d2c5680);
    t = t ^ ((t << 15) & 32'hefc60000);
    t = t ^ (t >> 18);
    y = rdata_r ^ (mix >> 1) ^ (mix[0] ? MT_MATRIX : 32'd0);
  end

  always_comb begin
    state_nxt = state_r; idx_nxt = idx_r; pos_nxt = pos_r;
    prev_nxt = prev_r; hi_nxt = hi_r; lo_nxt = lo_r; word_nxt = word_r;
    valid_nxt = 1'b0; pend_nxt = pend_r;
    raddr = idx_r; we = 1'b0; waddr = idx_r; wdata = sd;
    case (state_r)
      S_IDLE: begin
        if (pend_r || ctl.draw) begin
          pend_nxt = 1'b0;
          if (pos_r >= FULL) begin
            idx_nxt = '0; state_nxt = S_TW0;
          end else begin
            state_nxt = S_RD0;
          end
        end
      end
      S_SEED: begin
        // idx_r counts from 1; prev_r is the word before.
        we = 1'b1; wdata = sd; prev_nxt = sd;
        if (idx_r == LAST) state_nxt = S_IDLE;
        else idx_nxt = idx_r + 1'b1;
      end
      S_TW0: begin raddr = idx_r; state_nxt = S_TW1; end
      S_TW1: begin raddr = ip1[AW-1:0]; hi_nxt = rdata_r; state_nxt = S_TW2; end
      S_TW2: begin raddr = ipm[AW-1:0]; lo_nxt = rdata_r; state_nxt = S_TW3; end
      S_TW3: begin
        we = 1'b1; wdata = y;
        if (idx_r == LAST) begin
          pos_nxt = '0; state_nxt = S_RD0;
        end else begin
          idx_nxt = idx_r + 1'b1; state_nxt = S_TW0;
        end
      end
      S_RD0: begin raddr = pos_r[AW-1:0]; state_nxt = S_RD1; end
      S_RD1: begin raddr = pos_r[AW-1:0]; state_nxt = S_TEMP; end
      S_TEMP: begin
        word_nxt = t; valid_nxt = 1'b1; pos_nxt = pos_r + 1'b1; state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
    if (ctl.draw && state_r != S_IDLE) pend_nxt = 1'b1;
    if (ctl.seed) begin
      we = 1'b1; waddr = '0; wdata = seed_val;
      prev_nxt = seed_val; idx_nxt = AW'(1); pos_nxt = FULL;
      pend_nxt = 1'b0; state_nxt = S_SEED;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_SEED; idx_r <= AW'(1); pos_r <= FULL;
      valid_r <= 1'b0; pend_r <= 1'b0;
    end else begin
      state_r <= state_nxt; idx_r <= idx_nxt; pos_r <= pos_nxt;
      valid_r <= valid_nxt; pend_r <= pend_nxt;
    end
    prev_r <= prev_nxt; hi_r <= hi_nxt; lo_r <= lo_nxt; word_r <= word_nxt;
  end

  // Reset seed value is supplied by the top level on seed_val during reset.
  logic unused_req;
  assign unused_req = (state_r == S_REQ);

  assign sts.busy = (state_r != S_IDLE) || pend_r || unused_req;
  assign sts.word_valid = valid_r;
  assign word = word_r;

`ifndef ASSERT_OFF
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n) pos_r <= FULL)
    else $error("position beyond state size");
  a_valid_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |=> !valid_r) else $error("word valid longer than one cycle");
  a_seed_restart: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.seed |=> state_r == S_SEED && pos_r == FULL) else $error("seed did not restart");
`endif

endmodule

// ===== hdl/sphere_point_sampler_core.sv =====
// Top level of the sphere point sampler: three MT19937 generators and a shared arithmetic
// sequencer (square root, CORDIC, cube root, scaling). Depends on sps_pkg and sps_twister.
//
//  channel | direction | handshake            | payload
//  in_     | input     | in_valid / in_stall  | sps_in_t  (action, last_request)
//  out_    | output    | out_valid / out_stall| sps_out_t (x, y, z, last_point)
//  cfg_    | input     | cfg_we               | cfg_index, cfg_wdata (seed registers)
//
// Most of the work is the one-bit-per-cycle square root (32 steps), the 30 CORDIC
// rotations on one shared add/shift unit and the 30-step cube root recurrence, each step
// a square of the trial value and two half-width products of the cube.
// A twist runs once every 624 draws; it reads three words and writes one for each state word.
// After reset every generator, and after a seed write the generator written, sweeps its
// 624 words to seed itself; requests are held off (in_stall high) until the sweep is done.
// The result is held in an output register; in_stall stays high until it has been taken.
module sphere_point_sampler_core #(
  parameter int WORDS = sps_pkg::TWISTER_WORDS,
  parameter int FBITS = sps_pkg::FRAC_BITS
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  sps_pkg::sps_in_t in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output sps_pkg::sps_out_t out_data,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [31:0]      cfg_wdata
);
  import sps_pkg::*;

  localparam int SH = 30 - FBITS;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DRAW = 4'd1;   // wait for angle and height words
  localparam logic [3:0] S_U2 = 4'd2;
  localparam logic [3:0] S_SQRT = 4'd3;
  localparam logic [3:0] S_GAIN = 4'd4;
  localparam logic [3:0] S_CORD = 4'd5;
  localparam logic [3:0] S_QUAD = 4'd6;
  localparam logic [3:0] S_RAD = 4'd7;    // wait for radius word
  localparam logic [3:0] S_CBRT = 4'd8;   // square of trial
  localparam logic [3:0] S_CBR2 = 4'd9;   // upper half of the cube
  localparam logic [3:0] S_SCL = 4'd10;
  localparam logic [3:0] S_OUT = 4'd11;
  localparam logic [3:0] S_CBR3 = 4'd12;  // lower half of the cube and compare

  sps_gen_ctl_t ctl_a, ctl_h, ctl_r;
  sps_gen_sts_t sts_a, sts_h, sts_r;
  logic [31:0] word_a, word_h, word_r;
  logic [31:0] seed_a, seed_h, seed_r;

  // During reset the seeding sweep starts from the reset seeds; word 0 is loaded
  // by a seed pulse in the first cycle after reset.
  logic boot_r;
  always_ff @(posedge clk) begin
    if (!rst_n) boot_r <= 1'b1;
    else boot_r <= 1'b0;
  end

  assign seed_a = boot_r ? 32'd0 : cfg_wdata;
  assign seed_h = boot_r ? 32'd1 : cfg_wdata;
  assign seed_r = boot_r ? 32'd2 : cfg_wdata;

  logic draw_ah, draw_r;
  assign ctl_a.seed = boot_r || (cfg_we && cfg_index == CFG_SEED_ANGLE);
  assign ctl_h.seed = boot_r || (cfg_we && cfg_index == CFG_SEED_HEIGHT);
  assign ctl_r.seed = boot_r || (cfg_we && cfg_index == CFG_SEED_RADIUS);
  assign ctl_a.draw = draw_ah;
  assign ctl_h.draw = draw_ah;
  assign ctl_r.draw = draw_r;

  sps_twister #(.WORDS(WORDS)) u_tw_a (.clk, .rst_n, .ctl(ctl_a), .seed_val(seed_a),
    .sts(sts_a), .word(word_a));
  sps_twister #(.WORDS(WORDS)) u_tw_h (.clk, .rst_n, .ctl(ctl_h), .seed_val(seed_h),
    .sts(sts_h), .word(word_h));
  sps_twister #(.WORDS(WORDS)) u_tw_r (.clk, .rst_n, .ctl(ctl_r), .seed_val(seed_r),
    .sts(sts_r), .word(word_r));

  logic [3:0] state_r, state_nxt;
  logic [5:0] cnt_r, cnt_nxt;
  logic act_r, act_nxt, lastq_r, lastq_nxt;
  logic got_a_r, got_a_nxt, got_h_r, got_h_nxt;
  logic [31:0] aw_r, aw_nxt, hw_r, hw_nxt, w_r, w_nxt;
  logic signed [31:0] u_r, u_nxt;
  // Square root: remainder, root, trial bit.
  logic [63:0] sq_n_r, sq_n_nxt, sq_res_r, sq_res_nxt, sq_one_r, sq_one_nxt;
  logic signed [33:0] x_r, x_nxt, y_r, y_nxt;
  logic signed [32:0] z_r, z_nxt;
  logic [1:0] q_r, q_nxt;
  logic [29:0] k_r, k_nxt;
  logic [59:0] sq_r, sq_nxt;
  logic [59:0] cub_hi_r, cub_hi_nxt;
  logic signed [31:0] px_r, px_nxt, py_r, py_nxt;
  logic [1:0] sc_r, sc_nxt;
  logic out_valid_r, out_valid_nxt;
  sps_out_t out_r, out_nxt;

  logic signed [63:0] uu;
  logic [63:0] rone;
  logic [29:0] trial;
  logic [59:0] cube_hi, cube_lo;
  logic [60:0] ctop, lim;
  logic fits;
  logic signed [33:0] dx, dy;
  logic signed [33:0] rx, ry;
  logic signed [31:0] cx, cy, sv;
  logic signed [63:0] prod;
  logic signed [31:0] scaled;
  logic [4:0] ci;
  logic [31:0] qsum;
  logic [31:0] hsel;

  function automatic logic signed [31:0] clamp34(input logic signed [33:0] v);
    if (v > 34'sd1073741824) return 32'sd1073741824;
    if (v < -34'sd1073741824) return -32'sd1073741824;
    return v[31:0];
  endfunction

  function automatic logic [31:0] to_out(input logic signed [31:0] v);
    logic signed [32:0] t;
    begin
      if (SH == 0) return v;
      t = 33'(v) + (33'sd1 <<< (SH - 1));
      t = t >>> SH;
      return t[31:0];
    end
  endfunction

  always_comb begin
    ci = cnt_r[4:0];
    uu = 64'(u_r) * 64'(u_r);
    rone = sq_res_r + sq_one_r;
    dx = y_r >>> ci;
    dy = x_r >>> ci;
    trial = k_r | (30'd1 << ci);
    // The cube is built as two 30 by 30 products, upper and lower half of the square.
    cube_hi = 60'(sq_r[59:30]) * 60'(trial);
    cube_lo = 60'(sq_r[29:0]) * 60'(trial);
    ctop = 61'(cub_hi_r) + 61'(cube_lo[59:30]);
    lim = 61'({w_r, 28'd0});
    fits = (ctop < lim) || (ctop == lim && cube_lo[29:0] == 30'd0);
    case (q_r)
      2'd0: begin rx = x_r; ry = y_r; end
      2'd1: begin rx = -y_r; ry = x_r; end
      2'd2: begin rx = -x_r; ry = -y_r; end
      default: begin rx = y_r; ry = -x_r; end
    endcase
    cx = clamp34(rx);
    cy = clamp34(ry);
    case (sc_r)
      2'd0: sv = px_r;
      2'd1: sv = py_r;
      default: sv = u_r;
    endcase
    prod = 64'(sv) * 64'($signed({2'b0, k_r}));
    scaled = prod[61:30];
    qsum = aw_r + 32'h20000000;
    hsel = sts_h.word_valid ? word_h : hw_r;
  end

  always_comb begin
    state_nxt = state_r; cnt_nxt = cnt_r; act_nxt = act_r; lastq_nxt = lastq_r;
    got_a_nxt = got_a_r; got_h_nxt = got_h_r; aw_nxt = aw_r; hw_nxt = hw_r; w_nxt = w_r;
    u_nxt = u_r; sq_n_nxt = sq_n_r; sq_res_nxt = sq_res_r; sq_one_nxt = sq_one_r;
    x_nxt = x_r; y_nxt = y_r; z_nxt = z_r; q_nxt = q_r; k_nxt = k_r; sq_nxt = sq_r;
    cub_hi_nxt = cub_hi_r;
    px_nxt = px_r; py_nxt = py_r; sc_nxt = sc_r;
    out_valid_nxt = out_valid_r; out_nxt = out_r;
    draw_ah = 1'b0; draw_r = 1'b0;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid && !in_stall) begin
          act_nxt = in_data.action; lastq_nxt = in_data.last_request;
          got_a_nxt = 1'b0; got_h_nxt = 1'b0; draw_ah = 1'b1; state_nxt = S_DRAW;
        end
      end
      S_DRAW: begin
        if (sts_a.word_valid) begin aw_nxt = word_a; got_a_nxt = 1'b1; end
        if (sts_h.word_valid) begin hw_nxt = word_h; got_h_nxt = 1'b1; end
        if ((got_a_r || sts_a.word_valid) && (got_h_r || sts_h.word_valid))
          state_nxt = S_U2;
        u_nxt = $signed({1'b0, hsel[31:1]}) - 32'sd1073741824;
      end
      S_U2: begin
        sq_n_nxt = ((64'd1 << 30) - (64'(uu) >> 30)) << 30;
        sq_res_nxt = '0; sq_one_nxt = 64'd1 << 62; cnt_nxt = 6'd0; state_nxt = S_SQRT;
        q_nxt = qsum[31:30];
      end
      S_SQRT: begin
        if (sq_one_r == 0) begin
          state_nxt = S_GAIN;
        end else begin
          if (sq_n_r >= rone) begin
            sq_n_nxt = sq_n_r - rone; sq_res_nxt = (sq_res_r >> 1) + sq_one_r;
          end else begin
            sq_res_nxt = sq_res_r >> 1;
          end
          sq_one_nxt = sq_one_r >> 2;
        end
      end
      S_GAIN: begin
        x_nxt = 34'((64'(sq_res_r[31:0]) * 64'(INV_GAIN_Q30)) >> 30);
        y_nxt = '0;
        // The residual angle is a signed 32-bit value in turn units.
        z_nxt = 33'($signed(aw_r - {q_r, 30'd0}));
        cnt_nxt = 6'd0; state_nxt = S_CORD;
      end
      S_CORD: begin
        if (z_r >= 0) begin
          x_nxt = x_r - dx; y_nxt = y_r + dy; z_nxt = z_r - $signed({1'b0, cordic_angle(ci)});
        end else begin
          x_nxt = x_r + dx; y_nxt = y_r - dy; z_nxt = z_r + $signed({1'b0, cordic_angle(ci)});
        end
        if (cnt_r == 6'(CORDIC_STEPS - 1)) state_nxt = S_QUAD;
        else cnt_nxt = cnt_r + 1'b1;
      end
      S_QUAD: begin
        px_nxt = cx; py_nxt = cy;
        if (act_r) begin
          draw_r = 1'b1; state_nxt = S_RAD;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_RAD: begin
        if (sts_r.word_valid) begin
          w_nxt = word_r; k_nxt = '0; cnt_nxt = 6'd29; state_nxt = S_CBRT;
        end
      end
      S_CBRT: begin
        sq_nxt = 60'(trial) * 60'(trial); state_nxt = S_CBR2;
      end
      S_CBR2: begin
        cub_hi_nxt = cube_hi; state_nxt = S_CBR3;
      end
      S_CBR3: begin
        if (fits) k_nxt = trial;
        if (cnt_r == 0) begin
          sc_nxt = 2'd0; state_nxt = S_SCL;
        end else begin
          cnt_nxt = cnt_r - 1'b1; state_nxt = S_CBRT;
        end
      end
      S_SCL: begin
        case (sc_r)
          2'd0: px_nxt = scaled;
          2'd1: py_nxt = scaled;
          default: u_nxt = scaled;
        endcase
        if (sc_r == 2'd2) state_nxt = S_OUT;
        else sc_nxt = sc_r + 1'b1;
      end
      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_nxt.x_coord = to_out(px_r);
          out_nxt.y_coord = to_out(py_r);
          out_nxt.z_coord = to_out(u_r);
          out_nxt.last_point = lastq_r;
          out_valid_nxt = 1'b1; state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; out_valid_r <= 1'b0; got_a_r <= 1'b0; got_h_r <= 1'b0;
    end else begin
      state_r <= state_nxt; out_valid_r <= out_valid_nxt;
      got_a_r <= got_a_nxt; got_h_r <= got_h_nxt;
    end
    cnt_r <= cnt_nxt; act_r <= act_nxt; lastq_r <= lastq_nxt;
    aw_r <= aw_nxt; hw_r <= hw_nxt; w_r <= w_nxt; u_r <= u_nxt;
    sq_n_r <= sq_n_nxt; sq_res_r <= sq_res_nxt; sq_one_r <= sq_one_nxt;
    x_r <= x_nxt; y_r <= y_nxt; z_r <= z_nxt; q_r <= q_nxt; k_r <= k_nxt; sq_r <= sq_nxt;
    cub_hi_r <= cub_hi_nxt;
    px_r <= px_nxt; py_r <= py_nxt; sc_r <= sc_nxt; out_r <= out_nxt;
  end

  // A new request waits for an idle sequencer, an empty output register and settled
  // generators.
  assign in_stall = (state_r != S_IDLE) || out_valid_r || boot_r || !rst_n ||
                    sts_a.busy || sts_h.busy || sts_r.busy;
  assign out_valid = out_valid_r;
  assign out_data = out_r;

`ifndef ASSERT_OFF
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> state_r == S_DRAW) else $error("request not started");
  a_cordic_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CORD |-> cnt_r < 6'(CORDIC_STEPS)) else $error("CORDIC step overrun");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> out_valid_r && $stable(out_r))
    else $error("stalled result changed");
  a_no_stray_radius: assert property (@(posedge clk) disable iff (!rst_n)
    draw_r |-> act_r) else $error("radius drawn for surface point");
`endif

endmodule
